// ===== hw/rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear-probing key/value table.
// ----------------------------------------------------------------------------
package lph_pkg;

   localparam int unsigned KEY_BITS    = 64;
   localparam int unsigned HALF_BITS   = 32;
   localparam int unsigned OP_BITS     = 2;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned VALUE_IO_BITS = 32;

   localparam int unsigned TABLE_SLOTS_DEFAULT = 1024;
   localparam int unsigned VALUE_BITS_DEFAULT  = 32;

   // Multiplicative hash: p = key * HASH_MULT, h = p ^ (p >> HASH_FOLD).
   localparam logic [KEY_BITS-1:0] HASH_MULT = 64'hff51_afd7_ed55_8ccd;
   localparam int unsigned         HASH_FOLD = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_ZERO_KEY = 2'd2,
      STATUS_RSVD     = 2'd3
   } status_type;

endpackage

// ===== hw/rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing, held in block RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Handshake
//   -------   -------------------------------------   ---------------------------
//   request   req_op, req_key, req_value              beat when start && !busy
//   response  rsp_found, rsp_value_out, rsp_status    beat on each rsp_valid cycle
//
// After reset the table runs a clearing pass over all TABLE_SLOTS slots, one
// slot per cycle, and holds busy high for its whole length.
// A request with a zero key or the unused opcode answers on the next cycle and
// leaves busy low. Any other request holds busy high from its beat while the
// home slot is hashed and then while the probe examines slots; with a table
// size that is not a power of two the home slot is also reduced digit by digit.
// The key memory's single read port limits the probe to one slot per cycle,
// and the shared 32x32 multiplier builds the hash from three partial products.
// The receiver cannot stall: each response is presented for exactly one cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int unsigned TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEFAULT,
   parameter int unsigned VALUE_BITS  = lph_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lph_pkg::OP_BITS-1:0]           req_op,
   input  logic [lph_pkg::KEY_BITS-1:0]          req_key,
   input  logic [lph_pkg::VALUE_IO_BITS-1:0]     req_value,
   output logic                                  rsp_valid,
   output logic                                  rsp_found,
   output logic [lph_pkg::VALUE_IO_BITS-1:0]     rsp_value_out,
   output logic [lph_pkg::STATUS_BITS-1:0]       rsp_status
);

   import lph_pkg::*;

   localparam int unsigned IDXW   = $clog2(TABLE_SLOTS);
   localparam int unsigned CNTW   = $clog2(TABLE_SLOTS + 1);
   localparam int unsigned KRAM_W = KEY_BITS + 1;

   localparam logic [IDXW-1:0] LAST_ADDR = IDXW'(TABLE_SLOTS - 1);
   localparam logic [CNTW-1:0] SLOTS_CNT = CNTW'(TABLE_SLOTS);
   localparam logic [CNTW-1:0] LAST_CNT  = CNTW'(TABLE_SLOTS - 1);

   // Main controller. CLEAR sweeps the key memory after reset, HASH waits for
   // the home slot, PROBE walks the table one slot per cycle.
   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_HASH  = 4'b0100,
      ST_PROBE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDXW-1:0]         clr_addr_ff, clr_addr_in;
   op_type                  op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;

   // Probe pointers: the issue side runs one slot ahead of the evaluate side
   // so that a slot is examined every cycle despite the read latency.
   logic [IDXW-1:0]         issue_addr_ff, issue_addr_in;
   logic [CNTW-1:0]         issue_cnt_ff, issue_cnt_in;
   logic [IDXW-1:0]         eval_addr_ff, eval_addr_in;
   logic [CNTW-1:0]         eval_cnt_ff, eval_cnt_in;
   logic                    rd_pend_ff, rd_pend_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [VALUE_IO_BITS-1:0] rsp_value_ff, rsp_value_in;
   status_type              rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    req_trivial;
   logic                    hash_start;
   logic                    hash_done;
   logic [IDXW-1:0]         hash_home;

   logic                    kram_we;
   logic [IDXW-1:0]         kram_waddr;
   logic [KRAM_W-1:0]       kram_wdata;
   logic                    rd_en;
   logic [KRAM_W-1:0]       kram_rdata;
   logic                    vram_we;
   logic [VALUE_BITS-1:0]   vram_rdata;

   logic                    rd_occ;
   logic [KEY_BITS-1:0]     rd_key;
   logic                    key_hit;
   logic                    stop;
   logic [VALUE_BITS-1:0]   value_store;
   logic [VALUE_IO_BITS-1:0] value_read;

   // Stored values keep the low VALUE_BITS bits; responses carry the low
   // 32 bits of the stored value.
   generate
      if (VALUE_BITS <= VALUE_IO_BITS) begin : g_narrow
         assign value_store = req_value[VALUE_BITS-1:0];
         if (VALUE_BITS == VALUE_IO_BITS) begin : g_same
            assign value_read = vram_rdata;
         end else begin : g_ext
            assign value_read = {{(VALUE_IO_BITS - VALUE_BITS){1'b0}}, vram_rdata};
         end
      end else begin : g_wide
         assign value_store = {{(VALUE_BITS - VALUE_IO_BITS){1'b0}}, req_value};
         assign value_read  = vram_rdata[VALUE_IO_BITS-1:0];
      end
   endgenerate

   function automatic logic [IDXW-1:0] next_slot(input logic [IDXW-1:0] a);
      next_slot = (a == LAST_ADDR) ? '0 : a + 1'b1;
   endfunction

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign req_trivial = (req_op == OP_NONE) || (req_key == '0);
   assign hash_start  = accept && !req_trivial;

   // Slot contents as returned by the key memory: {occupied, key}.
   assign rd_occ  = kram_rdata[KEY_BITS];
   assign rd_key  = kram_rdata[KEY_BITS-1:0];
   assign key_hit = (rd_key == key_ff);
   assign rd_en   = (state_ff == ST_PROBE) && (issue_cnt_ff != SLOTS_CNT);

   // An insert stops at the first free slot or at its own key; a lookup or a
   // remove stops at its key (tombstone or not) or at a never-used slot.
   always_comb begin
      if (op_ff == OP_INSERT) begin
         stop = !rd_occ || key_hit;
      end else begin
         stop = key_hit || (rd_key == '0);
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      issue_addr_in = issue_addr_ff;
      issue_cnt_in  = issue_cnt_ff;
      eval_addr_in  = eval_addr_ff;
      eval_cnt_in   = eval_cnt_ff;
      rd_pend_in    = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      kram_we       = 1'b0;
      kram_waddr    = eval_addr_ff;
      kram_wdata    = {1'b1, key_ff};
      vram_we       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            kram_we     = 1'b1;
            kram_waddr  = clr_addr_ff;
            kram_wdata  = '0;
            clr_addr_in = next_slot(clr_addr_ff);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_op);
               key_in   = req_key;
               value_in = value_store;
               if (req_op == OP_NONE) begin
                  rsp_valid_in = 1'b1;
               end else if (req_key == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_ZERO_KEY;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               issue_addr_in = hash_home;
               issue_cnt_in  = '0;
               eval_cnt_in   = '0;
               state_in      = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (rd_en) begin
               issue_addr_in = next_slot(issue_addr_ff);
               issue_cnt_in  = issue_cnt_ff + 1'b1;
            end
            rd_pend_in   = rd_en;
            eval_addr_in = issue_addr_ff;
            if (rd_pend_ff) begin
               eval_cnt_in = eval_cnt_ff + 1'b1;
               if (stop) begin
                  if (op_ff == OP_INSERT) begin
                     // A free slot takes key and value; a live match only
                     // has its value replaced.
                     kram_we    = !rd_occ;
                     kram_wdata = {1'b1, key_ff};
                     vram_we    = 1'b1;
                  end else begin
                     rsp_found_in = key_hit && rd_occ;
                     rsp_value_in = (key_hit && rd_occ) ? value_read : '0;
                     // Remove leaves the key behind as a tombstone.
                     kram_we      = (op_ff == OP_REMOVE) && key_hit;
                     kram_wdata   = {1'b0, key_ff};
                  end
               end
               if (stop || (eval_cnt_ff == LAST_CNT)) begin
                  rsp_valid_in = 1'b1;
                  if ((op_ff == OP_INSERT) && !stop) begin
                     rsp_status_in = STATUS_FULL;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      issue_addr_ff <= issue_addr_in;
      issue_cnt_ff  <= issue_cnt_in;
      eval_addr_ff  <= eval_addr_in;
      eval_cnt_ff   <= eval_cnt_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   lph_hash #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key),
      .done  (hash_done),
      .home  (hash_home)
   );

   // Occupied flag and key of each slot.
   lph_ram #(
      .WIDTH (KRAM_W),
      .DEPTH (TABLE_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (kram_we),
      .wr_addr (kram_waddr),
      .wr_data (kram_wdata),
      .rd_en   (rd_en),
      .rd_addr (issue_addr_ff),
      .rd_data (kram_rdata)
   );

   // Values; only read back from occupied slots, so never cleared.
   lph_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_SLOTS)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (vram_we),
      .wr_addr (eval_addr_ff),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_addr_ff),
      .rd_data (vram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   // A request that needs no table access answers on the very next cycle.
   a_trivial_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && req_trivial) |=> rsp_valid)
      else $error("trivial request did not answer on the next cycle");

   // The hash unit only reports while the controller is waiting for it.
   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == ST_HASH))
      else $error("hash result arrived outside the hash wait");

   // Probing never examines more than one full pass over the table.
   a_probe_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (eval_cnt_ff != SLOTS_CNT))
      else $error("probe went past one pass over the table");

   // A hit is always reported with status ok.
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == STATUS_OK))
      else $error("hit reported with a non-ok status");

endmodule

// ===== hw/rtl/lph_ram.sv =====
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lph_hash.sv =====
// ----------------------------------------------------------------------------
// lph_hash
// Home-slot unit: 64-bit multiply from three partial products on a shared
// 32x32 multiplier, fold, then reduction to a slot index. For a table size
// that is not a power of two the folded hash is reduced 16 bits at a time by
// reciprocal multiplication and one correcting subtraction per digit.
// ----------------------------------------------------------------------------
module lph_hash #(
   parameter int unsigned TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lph_pkg::KEY_BITS-1:0]   key,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] home
);

   import lph_pkg::*;

   localparam int unsigned IDXW       = $clog2(TABLE_SLOTS);
   localparam bit          IS_POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam int unsigned DIGIT_BITS = 16;
   localparam logic [1:0]  LAST_DIGIT = 2'(KEY_BITS / DIGIT_BITS - 1);
   localparam logic [HALF_BITS-1:0] SLOTS_H   = HALF_BITS'(TABLE_SLOTS);
   localparam logic [HALF_BITS-1:0] RED_RECIP =
      HALF_BITS'((64'd1 << HALF_BITS) / TABLE_SLOTS);
   localparam logic [HALF_BITS-1:0] MULT_LO = HASH_MULT[HALF_BITS-1:0];
   localparam logic [HALF_BITS-1:0] MULT_HI = HASH_MULT[KEY_BITS-1:HALF_BITS];

   typedef enum logic [6:0] {
      H_IDLE   = 7'b0000001,
      H_MUL_LL = 7'b0000010,
      H_MUL_LH = 7'b0000100,
      H_MUL_HL = 7'b0001000,
      H_FOLD   = 7'b0010000,
      H_RED_Q  = 7'b0100000,
      H_RED_R  = 7'b1000000
   } hstate_type;

   hstate_type            state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   prod_ff, prod_in;
   logic [KEY_BITS-1:0]   lo_ff, lo_in;
   logic [HALF_BITS-1:0]  hi_ff, hi_in;
   logic [KEY_BITS-1:0]   h_ff, h_in;
   logic [IDXW-1:0]       rem_ff, rem_in;
   logic [1:0]            dig_cnt_ff, dig_cnt_in;
   logic [IDXW-1:0]       home_ff, home_in;
   logic                  done_ff, done_in;

   logic [HALF_BITS-1:0]  mul_a, mul_b;
   logic [KEY_BITS-1:0]   mul_p;
   logic [HALF_BITS-1:0]  p_hi;
   logic [KEY_BITS-1:0]   h_fold;
   logic [HALF_BITS-1:0]  red_x;
   logic [HALF_BITS-1:0]  red_r;
   logic [HALF_BITS-1:0]  red_rem;

   always_comb begin
      case (state_ff)
         H_MUL_LH: begin
            mul_a = key_ff[HALF_BITS-1:0];
            mul_b = MULT_HI;
         end
         H_MUL_HL: begin
            mul_a = key_ff[KEY_BITS-1:HALF_BITS];
            mul_b = MULT_LO;
         end
         H_RED_Q: begin
            mul_a = red_x;
            mul_b = RED_RECIP;
         end
         H_RED_R: begin
            mul_a = prod_ff[KEY_BITS-1:HALF_BITS];
            mul_b = SLOTS_H;
         end
         default: begin
            mul_a = key_ff[HALF_BITS-1:0];
            mul_b = MULT_LO;
         end
      endcase
      mul_p = mul_a * mul_b;

      // High word of the 64-bit product: cross terms only matter modulo 2^32.
      p_hi   = lo_ff[KEY_BITS-1:HALF_BITS] + hi_ff + prod_ff[HALF_BITS-1:0];
      h_fold = {p_hi, lo_ff[HALF_BITS-1:0] ^ p_hi};

      // Next 16-bit digit appended to the running remainder. The quotient
      // estimate from the reciprocal is low by at most one, so a single
      // compare and subtract finishes the digit.
      red_x   = {DIGIT_BITS'(rem_ff), h_ff[KEY_BITS-1 -: DIGIT_BITS]};
      red_r   = red_x - mul_p[HALF_BITS-1:0];
      red_rem = (red_r >= SLOTS_H) ? (red_r - SLOTS_H) : red_r;
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      prod_in    = prod_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      h_in       = h_ff;
      rem_in     = rem_ff;
      dig_cnt_in = dig_cnt_ff;
      home_in    = home_ff;
      done_in    = 1'b0;

      case (state_ff)
         H_IDLE: begin
            if (start) begin
               key_in   = key;
               state_in = H_MUL_LL;
            end
         end
         H_MUL_LL: begin
            prod_in  = mul_p;
            state_in = H_MUL_LH;
         end
         H_MUL_LH: begin
            lo_in    = prod_ff;
            prod_in  = mul_p;
            state_in = H_MUL_HL;
         end
         H_MUL_HL: begin
            hi_in    = prod_ff[HALF_BITS-1:0];
            prod_in  = mul_p;
            state_in = H_FOLD;
         end
         H_FOLD: begin
            if (IS_POW2) begin
               home_in  = h_fold[IDXW-1:0];
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               h_in       = h_fold;
               rem_in     = '0;
               dig_cnt_in = '0;
               state_in   = H_RED_Q;
            end
         end
         H_RED_Q: begin
            prod_in  = mul_p;
            state_in = H_RED_R;
         end
         H_RED_R: begin
            h_in       = {h_ff[KEY_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
            rem_in     = red_rem[IDXW-1:0];
            dig_cnt_in = dig_cnt_ff + 1'b1;
            if (dig_cnt_ff == LAST_DIGIT) begin
               home_in  = red_rem[IDXW-1:0];
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               state_in = H_RED_Q;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      key_ff     <= key_in;
      prod_ff    <= prod_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      h_ff       <= h_in;
      rem_ff     <= rem_in;
      dig_cnt_ff <= dig_cnt_in;
      home_ff    <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule
